FILE: rtl/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define CHK_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/brld_pkg.sv
package brld_pkg;

  localparam int ByteW  = 8;
  localparam int CountW = 7;
  localparam int TotalW = 24;

  typedef enum logic [1:0] {
    PH_CTRL    = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  // decoder state carried from one beat to the next
  typedef struct packed {
    phase_t              phase;
    logic [CountW-1:0]   run_left;
    logic [TotalW-1:0]   bytes_left;
    logic                finished;
  } dec_state_t;

  // one result beat
  typedef struct packed {
    logic [ByteW-1:0]  value;
    logic [CountW-1:0] count;
    logic              done;
    logic              err;
  } dec_result_t;

endpackage

FILE: rtl/brld_step.sv
module brld_step import brld_pkg::*; (
  input  dec_state_t        cur,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              stream_end,
  output dec_state_t        nxt,
  output logic              emit,
  output dec_result_t       res
);

  logic [CountW-1:0] raw_count;
  logic [CountW-1:0] clip_count;
  logic [TotalW-1:0] left_next;

  // clip the run to what is still expected
  always_comb begin
    if (cur.bytes_left < {{(TotalW-CountW){1'b0}}, raw_count}) begin
      clip_count = cur.bytes_left[CountW-1:0];
    end else begin
      clip_count = raw_count;
    end
    left_next = cur.bytes_left - {{(TotalW-CountW){1'b0}}, clip_count};
  end

  always_comb begin
    nxt       = cur;
    emit      = 1'b0;
    raw_count = '0;
    res       = '0;
    if (cur.finished) begin
      // everything after done or error is dropped
    end else if (stream_end) begin
      nxt.finished = 1'b1;
      nxt.phase    = PH_CTRL;
      nxt.run_left = '0;
      emit         = 1'b1;
      res.err      = 1'b1;
    end else begin
      case (cur.phase)
        PH_REPEAT: begin
          nxt.phase    = PH_CTRL;
          nxt.run_left = '0;
          raw_count    = cur.run_left;
          // zero control byte swallows its value byte
          emit         = (cur.run_left != '0);
        end
        PH_LITERAL: begin
          if (cur.run_left == '0) begin
            nxt.phase = PH_CTRL;
          end else begin
            nxt.run_left = cur.run_left - CountW'(1);
          end
          raw_count = CountW'(1);
          emit      = 1'b1;
        end
        default: begin
          nxt.phase    = data_byte[ByteW-1] ? PH_LITERAL : PH_REPEAT;
          nxt.run_left = data_byte[CountW-1:0];
        end
      endcase
      if (emit) begin
        res.value      = data_byte;
        res.count      = clip_count;
        nxt.bytes_left = left_next;
        if (left_next == '0) begin
          res.done     = 1'b1;
          nxt.finished = 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/byte_run_length_decoder.sv
// byte run-length decoder, packbits-style control bytes. one compressed byte
// enters per beat on the input channel and each beat gives zero or one result
// beat: a control byte 1..127 makes the next byte a run of that many copies,
// a control byte 128..255 makes the next (control - 127) bytes literals with
// count 1, and a control byte of zero swallows the byte after it. the block
// stops once total_bytes decoded bytes are out: the run that reaches the total
// is clipped and marked image_done, later beats are dropped. a stream_end beat
// before the total gives one result with stream_error set and count 0.
// throughput is one beat per cycle while in_stall is low; a beat goes to the
// input register, then is decoded into the result register. a beat that makes
// a result waits in the input register while the result register holds a
// stalled beat, which stalls the input; beats with no result never wait.
// writing total_bytes restarts the decoder; the user does it while the block
// is idle, which the block does not enforce (it waits for an empty input
// register only). a total of zero means finished with no output at all.
module byte_run_length_decoder import brld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // compressed byte channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              stream_end,
  // decoded run channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ByteW-1:0]  out_value,
  output logic [CountW-1:0] out_count,
  output logic              image_done,
  output logic              stream_error,
  // total_bytes register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TotalW-1:0] total_bytes
);

  // input register
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_end;

  dec_state_t  st;
  dec_state_t  st_next;
  logic        step_emit;
  dec_result_t step_res;

  logic out_free;
  logic s1_go;
  logic in_accept;
  logic cfg_write;

  brld_step u_step (
    .cur        (st),
    .data_byte  (s1_byte),
    .stream_end (s1_end),
    .nxt        (st_next),
    .emit       (step_emit),
    .res        (step_res)
  );

  // result register is free when empty or being taken this cycle
  assign out_free  = !out_valid || !out_stall;
  // beats with no result never wait on the output side
  assign s1_go     = s1_valid && (!step_emit || out_free);
  assign in_stall  = s1_valid && !s1_go;
  assign in_accept = in_valid && !in_stall;

  // config only lands with nothing in the input register
  assign cfg_ready = !s1_valid;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte <= data_byte;
      s1_end  <= stream_end;
    end
  end

  // decoder state; reset behaves as a write of total 1
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_CTRL;
      st.run_left   <= '0;
      st.bytes_left <= TotalW'(1);
      st.finished   <= 1'b0;
    end else if (cfg_write) begin
      st.phase      <= PH_CTRL;
      st.run_left   <= '0;
      st.bytes_left <= total_bytes;
      st.finished   <= (total_bytes == '0);
    end else if (s1_go) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && step_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step_emit) begin
      out_value    <= step_res.value;
      out_count    <= step_res.count;
      image_done   <= step_res.done;
      stream_error <= step_res.err;
    end
  end

endmodule

FILE: rtl/brld_checker.sv
`include "assert_macros.svh"

module brld_checker import brld_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ByteW-1:0]  out_value,
  input logic [CountW-1:0] out_count,
  input logic              image_done,
  input logic              stream_error
);

  logic                    out_beat;
  logic                    last_beat;
  logic                    out_held;
  logic                    err_out;
  logic                    run_out;
  logic [ByteW+CountW+1:0] out_bus;

  assign out_beat  = out_valid && !out_stall;
  assign last_beat = out_beat && (image_done || stream_error);
  assign out_held  = out_valid && out_stall;
  assign err_out   = out_valid && stream_error;
  assign run_out   = out_valid && !stream_error;
  assign out_bus   = {out_value, out_count, image_done, stream_error};

  `CHK_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable(out_bus), "held result moved")
  `CHK_SAME(a_err_shape, clk, rst, err_out, (out_count == '0) && !image_done, "bad error result")
  `CHK_SAME(a_count_nz, clk, rst, run_out, out_count != '0, "zero count result")
  `CHK_NEXT(a_quiet_after_end, clk, rst, last_beat, !out_valid, "result after done or error")

endmodule

bind byte_run_length_decoder brld_checker u_brld_checker (.*);

FILE: sim/tb_byte_run_length_decoder.sv
`timescale 1ns / 100ps

// self-checking bench for the byte run-length decoder
module tb_byte_run_length_decoder;
  import brld_pkg::*;

  localparam int IDLE_LIMIT    = 2000;   // cycles with no beat on any channel
  localparam int SETTLE_CYCLES = 8;      // settle time after the owed runs, plus margin
  localparam int RANDOM_BEATS  = 1200;
  localparam int MAX_IMAGE_BEATS = 150;

  // dut ports, every input known from time zero
  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [ByteW-1:0]  data_byte    = '0;
  logic              stream_end   = 1'b0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic [ByteW-1:0]  out_value;
  logic [CountW-1:0] out_count;
  logic              image_done;
  logic              stream_error;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [TotalW-1:0] total_bytes  = 24'd1;

  // decoder state as the bench predicts it
  logic [TotalW-1:0] dec_total;
  phase_t            dec_phase;
  logic [CountW-1:0] dec_run;
  logic [TotalW-1:0] dec_remaining;
  logic              dec_finished;

  // decoded runs still owed by the block, oldest first
  dec_result_t runs_due[$];
  dec_result_t run_want;

  int  mismatches  = 0;
  int  beats_fed   = 0;   // beats the decoder actually acts on
  int  burst_left  = 0;
  int  idle_cycles = 0;
  int  hold_cycles = 0;
  bit  hold_req    = 1'b0;
  bit  steady      = 1'b0;   // sender offers back to back when set

  byte_run_length_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_count    (out_count),
    .image_done   (image_done),
    .stream_error (stream_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .total_bytes  (total_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // a write of total_bytes starts a fresh image
  function automatic void restart_decoder();
    dec_phase     = PH_CTRL;
    dec_run       = '0;
    dec_remaining = dec_total;
    dec_finished  = (dec_total == '0);
  endfunction

  // queue one result; normal runs are clipped to what the image still needs
  function automatic void push_run(logic [ByteW-1:0] value, logic [CountW-1:0] count,
                                   logic err);
    dec_result_t r;
    r.done = 1'b0;
    if (!err) begin
      if (TotalW'(count) > dec_remaining)
        count = dec_remaining[CountW-1:0];
      dec_remaining = dec_remaining - TotalW'(count);
      if (dec_remaining == '0) begin
        r.done       = 1'b1;
        dec_finished = 1'b1;
      end
    end
    r.value = value;
    r.count = count;
    r.err   = err;
    runs_due.push_back(r);
  endfunction

  // one accepted compressed beat through the predicted decoder
  function automatic void decode_beat(logic [ByteW-1:0] b, logic last);
    logic [CountW-1:0] n;
    if (dec_finished)
      return;                       // done or failed image drops everything
    if (last) begin
      // stream ran dry before the total: error beat, count 0
      dec_finished = 1'b1;
      dec_phase    = PH_CTRL;
      dec_run      = '0;
      push_run('0, '0, 1'b1);
      return;
    end
    case (dec_phase)
      PH_REPEAT: begin
        n         = dec_run;
        dec_phase = PH_CTRL;
        dec_run   = '0;
        // control byte zero swallows its value byte
        if (n != '0)
          push_run(b, n, 1'b0);
      end
      PH_LITERAL: begin
        // dec_run counts the literals left after this one
        if (dec_run == '0)
          dec_phase = PH_CTRL;
        else
          dec_run = dec_run - CountW'(1);
        push_run(b, 7'd1, 1'b0);
      end
      default: begin
        // control byte: below 128 is a repeat, else 128 + (literals - 1)
        dec_phase = b[7] ? PH_LITERAL : PH_REPEAT;
        dec_run   = b[CountW-1:0];
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // one compressed beat; sender works in bursts, random gaps between unless steady
  task automatic send_beat(input logic [ByteW-1:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0 && !steady) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    data_byte  <= b;
    stream_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!dec_finished)
      beats_fed++;
    decode_beat(b, last);
  endtask

  // stop sending until every owed run is out, then let the pipe settle
  task automatic drain_runs(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (runs_due.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  // total_bytes write; only called with the decoder idle
  task automatic write_total(input logic [TotalW-1:0] total);
    cfg_valid   <= 1'b1;
    total_bytes <= total;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dec_total = total;
    restart_decoder();
  endtask

  // receiver: stall pattern changes mode now and then, long hold-off on request
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (int i = 0; i < hold_cycles; i++) @(posedge clk);
        hold_req = 1'b0;
      end
      else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;                          // free flow
          1:       out_stall <= ($urandom_range(0, 99) < 30);  // light
          2:       out_stall <= ($urandom_range(0, 99) < 75);  // heavy
          default: out_stall <= ~out_stall;                    // every other cycle
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  // each accepted result beat against the oldest owed run
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (runs_due.size() == 0) begin
        $error("result beat with none owed: out_value %0h out_count %0d", out_value, out_count);
        mismatches++;
      end
      else begin
        run_want = runs_due.pop_front();
        if (out_value !== run_want.value) begin
          $error("out_value: expected %0h, got %0h", run_want.value, out_value);
          mismatches++;
        end
        if (out_count !== run_want.count) begin
          $error("out_count: expected %0d, got %0d", run_want.count, out_count);
          mismatches++;
        end
        if (image_done !== run_want.done) begin
          $error("image_done: expected %0b, got %0b", run_want.done, image_done);
          mismatches++;
        end
        if (stream_error !== run_want.err) begin
          $error("stream_error: expected %0b, got %0b", run_want.err, stream_error);
          mismatches++;
        end
      end
    end
  end

  // watchdog: any beat on any channel resets the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[byte_run_length_decoder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // total left at its reset value of one: a long run is clipped at once
  task automatic test_reset_total();
    send_beat(8'd5, 1'b0);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h00, 1'b0);        // dropped after done
    send_beat(8'h7E, 1'b1);        // stream end after done, dropped too
  endtask

  // every kind of control byte with the largest total, then an early end
  task automatic test_repeat_and_literal();
    drain_runs(SETTLE_CYCLES);
    write_total(24'hFFFFFF);
    send_beat(8'd127, 1'b0);       // longest repeat
    send_beat(8'hFF, 1'b0);
    send_beat(8'd1, 1'b0);         // shortest repeat
    send_beat(8'h00, 1'b0);
    send_beat(8'd0, 1'b0);         // control zero eats its value byte
    send_beat(8'h55, 1'b0);
    send_beat(8'd128, 1'b0);       // single literal
    send_beat(8'h80, 1'b0);
    send_beat(8'd129, 1'b0);       // two literals
    send_beat(8'h01, 1'b0);
    send_beat(8'hFE, 1'b0);
    send_beat(8'hC7, 1'b1);        // stream ends long before the total
  endtask

  // runs that cross the total get clipped and mark done, later literals are dropped
  task automatic test_clipping();
    drain_runs(SETTLE_CYCLES);
    write_total(24'd200);
    send_beat(8'd127, 1'b0);
    send_beat(8'h3C, 1'b0);
    send_beat(8'd100, 1'b0);       // only 73 left
    send_beat(8'hC3, 1'b0);
    send_beat(8'd5, 1'b0);         // dropped
    drain_runs(SETTLE_CYCLES);
    write_total(24'd3);
    send_beat(8'd131, 1'b0);       // four literals, the fourth is past done
    send_beat(8'hAA, 1'b0);
    send_beat(8'h55, 1'b0);
    send_beat(8'hF0, 1'b0);
    send_beat(8'h0F, 1'b0);
  endtask

  // stream end as the first beat and right after a control byte
  task automatic test_early_end();
    drain_runs(SETTLE_CYCLES);
    write_total(24'd50);
    send_beat(8'($urandom), 1'b1);
    send_beat(8'($urandom), 1'b1); // second end is dropped
    drain_runs(SETTLE_CYCLES);
    write_total(24'd50);
    send_beat(8'd9, 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    drain_runs(SETTLE_CYCLES);
    write_total(24'd100000);
    hold_cycles = 200;
    hold_req    = 1'b1;
    steady      = 1'b1;
    send_beat(8'd255, 1'b0);       // 128 literals
    for (int i = 0; i < 128; i++)
      send_beat(8'($urandom), 1'b0);
    steady = 1'b0;
    wait (hold_req == 1'b0);
    // sender waits for every owed run, then carries on in the same image
    drain_runs(0);
    send_beat(8'd3, 1'b0);
    send_beat(8'h77, 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  // one image of well-formed packets with random content, some broken ones
  task automatic feed_image(input logic [TotalW-1:0] total);
    int first;
    int pick;
    int n;
    write_total(total);
    first = beats_fed;
    while (!dec_finished && beats_fed - first < MAX_IMAGE_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // repeat packet, count weighted to the ends
        n = $urandom_range(0, 99);
        n = (n < 4) ? 0 : (n < 14) ? 127 : (n < 24) ? 1 : $urandom_range(1, 127);
        send_beat(8'(n), 1'b0);
        // now and then the stream stops between control and value
        send_beat(8'($urandom), ($urandom_range(0, 49) == 0));
      end
      else if (pick < 85) begin
        // literal packet, mostly short, sometimes the longest
        n = ($urandom_range(0, 9) == 0) ? 128 : $urandom_range(1, 12);
        send_beat(8'(127 + n), 1'b0);
        for (int i = 0; i < n; i++) begin
          if (dec_finished)
            break;
          send_beat(8'($urandom), ($urandom_range(0, 199) == 0));
        end
      end
      else if (pick < 88)
        send_beat(8'($urandom), 1'b1);   // early end
      else if (pick < 91)
        drain_runs(0);                   // sender pause mid image
      else
        send_beat(8'($urandom), 1'b0);   // stray byte, shifts packet framing
    end
    if (!dec_finished)
      send_beat(8'($urandom), 1'b1);
    // trailing beats after the image ended are dropped
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_streams();
    int stop_at;
    int pick;
    logic [TotalW-1:0] total;
    stop_at = beats_fed + RANDOM_BEATS;
    while (beats_fed < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 5)
        total = 24'd1;
      else if (pick < 10)
        total = 24'hFFFFFF;
      else if (pick < 20)
        total = 24'($urandom_range(1, 24'hFFFFFF));
      else
        total = 24'($urandom_range(1, 400));
      drain_runs(SETTLE_CYCLES);
      steady = ($urandom_range(0, 3) == 0);
      feed_image(total);
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    dec_total = 24'd1;
    restart_decoder();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_total();
    test_repeat_and_literal();
    test_clipping();
    test_early_end();
    test_backpressure();
    test_random_streams();

    // every owed run out, then a settle time for anything stray
    drain_runs(SETTLE_CYCLES);
    if (mismatches == 0)
      $display("[byte_run_length_decoder] OK");
    else
      $display("[byte_run_length_decoder] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/brld_pkg.sv
rtl/brld_step.sv
rtl/byte_run_length_decoder.sv
rtl/brld_checker.sv
sim/tb_byte_run_length_decoder.sv
